// File: src/podl_pkg.sv
package podl_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CUR_W     = $clog2(NUM_SLOTS + 1);
    localparam int PRIO_W    = 13;
    localparam int IN_PRIO_W = 16;

    localparam logic signed [PRIO_W-1:0]    PRIO_LOW  = -13'sd2048;
    localparam logic signed [PRIO_W-1:0]    PRIO_HIGH = 13'sd2048;
    localparam logic signed [IN_PRIO_W-1:0] IN_LOW    = -16'sd2048;
    localparam logic signed [IN_PRIO_W-1:0] IN_HIGH   = 16'sd2048;

    typedef enum logic [1:0] {
        MODE_CREATE,
        MODE_SET_PRIO,
        MODE_DESTROY,
        MODE_FETCH
    } mode_t;

    typedef enum logic [1:0] {
        ORD_HOLD,
        ORD_MARK,
        ORD_REMOVE,
        ORD_RESORT
    } order_op_t;

    typedef enum logic [2:0] {
        DRT_HOLD,
        DRT_PUSH,
        DRT_UPDATE,
        DRT_REMOVE,
        DRT_POP
    } dirty_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESORT
    } state_t;

    typedef struct packed {
        logic                     valid;
        logic                     dirty;
        logic [SLOT_W-1:0]        slot;
        logic signed [PRIO_W-1:0] prio;
    } order_entry_t;

    typedef struct packed {
        logic                     valid;
        logic [SLOT_W-1:0]        slot;
        logic signed [PRIO_W-1:0] prio;
    } dirty_entry_t;

    typedef struct packed {
        order_op_t                op;
        logic [SLOT_W-1:0]        key;
        logic signed [PRIO_W-1:0] prio;
    } order_ctl_t;

    typedef struct packed {
        dirty_op_t                op;
        logic [SLOT_W-1:0]        key;
        logic signed [PRIO_W-1:0] prio;
    } dirty_ctl_t;

    function automatic logic signed [PRIO_W-1:0] clamp_prio(
        input logic signed [IN_PRIO_W-1:0] raw
    );
        logic signed [PRIO_W-1:0] res;
        if (raw < IN_LOW)
        begin
            res = PRIO_LOW;
        end
        else if (raw > IN_HIGH)
        begin
            res = PRIO_HIGH;
        end
        else
        begin
            res = raw[PRIO_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/podl_if.sv
interface podl_req_if import podl_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [SLOT_W-1:0]           slot;
    logic signed [IN_PRIO_W-1:0] new_priority;

    modport source (output valid, mode, slot, new_priority, input ready);
    modport sink   (input valid, mode, slot, new_priority, output ready);
endinterface

interface podl_rsp_if import podl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] task_slot;
    logic              found;

    modport source (output valid, task_slot, found, input ready);
    modport sink   (input valid, task_slot, found, output ready);
endinterface

// File: src/priority_ordered_dispatch_list_core.sv
// Channel | Dir | Payload                          | Transfer
// req     | in  | mode, slot, new_priority         | valid && ready
// rsp     | out | task_slot, found                 | valid && ready
//
// Create, set priority, destroy and a fetch that hits the cursor need no reorder state.
// A fetch that opens a round is accepted, then the order chain reinserts the dirty
// slots one at a time from the dirty stack, and then the head is returned.
// rst_n clears all cells, slot flags, the cursor and the FSM; no clearing pass.
// req stalls while a round reorders, or while rsp holds an untaken result.
module priority_ordered_dispatch_list_core import podl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    podl_req_if.sink req,
    podl_rsp_if.source rsp
);

    // Order list: a chain of cells, position 0 is the list head.
    order_ctl_t              ord_ctl;
    logic                    rem_first;
    order_entry_t            ord_q     [NUM_SLOTS];
    order_entry_t            ord_left  [NUM_SLOTS];
    order_entry_t            ord_right [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    ord_match;
    logic [NUM_SLOTS-1:0]    ord_cand;
    logic [NUM_SLOTS-1:0]    ord_rem_le;
    logic [NUM_SLOTS-1:0]    ord_cand_le;
    logic [NUM_SLOTS-1:0]    ord_cand_right;
    logic [NUM_SLOTS-1:0]    ord_rem_before;
    logic [NUM_SLOTS-1:0]    ord_cand_before;

    // Dirty list: a chain of cells used as a stack, position 0 is the top.
    dirty_ctl_t              drt_ctl;
    dirty_entry_t            drt_q     [NUM_SLOTS];
    dirty_entry_t            drt_left  [NUM_SLOTS];
    dirty_entry_t            drt_right [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]    drt_match;
    logic [NUM_SLOTS-1:0]    drt_rem_le;
    logic [NUM_SLOTS-1:0]    drt_rem_before;

    state_t                  state_reg, state_next;
    logic [CUR_W-1:0]        cursor_reg, cursor_next;
    logic                    round_ended_reg, round_ended_next;
    logic [NUM_SLOTS-1:0]    in_use_reg, in_use_next;
    logic [NUM_SLOTS-1:0]    slot_dirty_reg, slot_dirty_next;
    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic                    out_found_reg;

    logic                    accept;
    logic                    out_load;
    logic [SLOT_W-1:0]       out_slot_d;
    logic                    out_found_d;
    logic signed [PRIO_W-1:0] req_prio;
    logic [NUM_SLOTS-1:0]    cur_hit;
    logic [NUM_SLOTS-1:0]    del_ahead;
    logic                    cur_valid;
    logic [SLOT_W-1:0]       cur_slot;
    dirty_entry_t            push_entry;

    assign req_prio   = clamp_prio(req.new_priority);
    assign push_entry = '{valid: 1'b1, slot: req.slot, prio: req_prio};
    assign req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept     = req.valid && req.ready;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++)
        begin : g_cells
            if (gi == 0)
            begin : g_first
                assign ord_left[gi]        = '0;
                assign ord_rem_before[gi]  = 1'b0;
                assign ord_cand_before[gi] = 1'b0;
                assign drt_left[gi]        = push_entry;
                assign drt_rem_before[gi]  = 1'b0;
            end
            else
            begin : g_rest
                assign ord_left[gi]        = ord_q[gi-1];
                assign ord_rem_before[gi]  = ord_rem_le[gi-1];
                assign ord_cand_before[gi] = ord_cand_le[gi-1];
                assign drt_left[gi]        = drt_q[gi-1];
                assign drt_rem_before[gi]  = drt_rem_le[gi-1];
            end

            // past the last cell the list is empty: always a place to insert
            if (gi == NUM_SLOTS - 1)
            begin : g_last
                assign ord_right[gi]      = '0;
                assign ord_cand_right[gi] = 1'b1;
                assign drt_right[gi]      = '0;
            end
            else
            begin : g_inner
                assign ord_right[gi]      = ord_q[gi+1];
                assign ord_cand_right[gi] = ord_cand[gi+1];
                assign drt_right[gi]      = drt_q[gi+1];
            end

            podl_order_cell u_ord (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ord_ctl),
                .rem_first   (rem_first),
                .left        (ord_left[gi]),
                .right       (ord_right[gi]),
                .rem_before  (ord_rem_before[gi]),
                .cand_before (ord_cand_before[gi]),
                .cand_right  (ord_cand_right[gi]),
                .entry       (ord_q[gi]),
                .match       (ord_match[gi]),
                .cand        (ord_cand[gi]),
                .rem_le      (ord_rem_le[gi]),
                .cand_le     (ord_cand_le[gi])
            );

            podl_dirty_cell u_drt (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (drt_ctl),
                .left       (drt_left[gi]),
                .right      (drt_right[gi]),
                .rem_before (drt_rem_before[gi]),
                .entry      (drt_q[gi]),
                .match      (drt_match[gi]),
                .rem_le     (drt_rem_le[gi])
            );

            assign cur_hit[gi]   = (cursor_reg == CUR_W'(gi)) && ord_q[gi].valid;
            assign del_ahead[gi] = ord_match[gi] && (CUR_W'(gi) < cursor_reg);
        end
    endgenerate

    // The slot being reinserted lies before its new place when no candidate precedes it.
    assign rem_first = |(ord_match & ~ord_cand_le);
    assign cur_valid = |cur_hit;

    always_comb
    begin
        cur_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cur_hit[i])
            begin
                cur_slot = cur_slot | ord_q[i].slot;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        round_ended_next = round_ended_reg;
        in_use_next      = in_use_reg;
        slot_dirty_next  = slot_dirty_reg;
        ord_ctl          = '{op: ORD_HOLD, key: req.slot, prio: req_prio};
        drt_ctl          = '{op: DRT_HOLD, key: req.slot, prio: req_prio};
        out_load         = 1'b0;
        out_slot_d       = '0;
        out_found_d      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(req.mode))
                        MODE_CREATE:
                        begin
                            if (!in_use_reg[req.slot])
                            begin
                                in_use_next[req.slot]     = 1'b1;
                                slot_dirty_next[req.slot] = 1'b1;
                                drt_ctl.op                = DRT_PUSH;
                            end
                        end
                        MODE_SET_PRIO:
                        begin
                            if (in_use_reg[req.slot])
                            begin
                                if (slot_dirty_reg[req.slot])
                                begin
                                    // keep its stack place, refresh the priority
                                    drt_ctl.op = DRT_UPDATE;
                                end
                                else
                                begin
                                    slot_dirty_next[req.slot] = 1'b1;
                                    drt_ctl.op                = DRT_PUSH;
                                    ord_ctl.op                = ORD_MARK;
                                end
                            end
                        end
                        MODE_DESTROY:
                        begin
                            if (in_use_reg[req.slot])
                            begin
                                in_use_next[req.slot]     = 1'b0;
                                slot_dirty_next[req.slot] = 1'b0;
                                ord_ctl.op                = ORD_REMOVE;
                                drt_ctl.op                = DRT_REMOVE;
                                // entries behind a removed one move up a place
                                if (|del_ahead)
                                begin
                                    cursor_next = cursor_reg - CUR_W'(1);
                                end
                            end
                        end
                        MODE_FETCH:
                        begin
                            out_load = 1'b1;
                            if (cur_valid)
                            begin
                                out_slot_d  = cur_slot;
                                out_found_d = 1'b1;
                                cursor_next = cursor_reg + CUR_W'(1);
                            end
                            else if (!round_ended_reg)
                            begin
                                round_ended_next = 1'b1;
                            end
                            else
                            begin
                                // hold the answer until the dirty slots are back in order
                                out_load         = 1'b0;
                                round_ended_next = 1'b0;
                                state_next       = ST_RESORT;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_RESORT:
            begin
                if (drt_q[0].valid)
                begin
                    ord_ctl = '{op: ORD_RESORT, key: drt_q[0].slot, prio: drt_q[0].prio};
                    drt_ctl.op = DRT_POP;
                    slot_dirty_next[drt_q[0].slot] = 1'b0;
                end
                else
                begin
                    out_load    = 1'b1;
                    out_slot_d  = ord_q[0].valid ? ord_q[0].slot : '0;
                    out_found_d = ord_q[0].valid;
                    cursor_next = CUR_W'(1);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cursor_reg      <= CUR_W'(NUM_SLOTS);
            round_ended_reg <= 1'b1;
            in_use_reg      <= '0;
            slot_dirty_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            round_ended_reg <= round_ended_next;
            in_use_reg      <= in_use_next;
            slot_dirty_reg  <= slot_dirty_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_slot_reg  <= out_slot_d;
            out_found_reg <= out_found_d;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.task_slot = out_slot_reg;
    assign rsp.found     = out_found_reg;

    a_stack_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
        drt_q[0].valid == (|slot_dirty_reg))
        else $error("dirty stack top disagrees with dirty flags");

    a_no_req_in_resort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESORT) |-> !req.ready)
        else $error("request taken while reordering");

    a_resort_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESORT && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("round opened without a result");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUR_W'(NUM_SLOTS))
        else $error("cursor out of range");

    a_update_hits_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (drt_ctl.op == DRT_UPDATE) |-> (|drt_match))
        else $error("priority update on a slot missing from the dirty stack");

endmodule

// File: src/podl_order_cell.sv
module podl_order_cell import podl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  order_ctl_t   ctl,
    input  logic         rem_first,
    input  order_entry_t left,
    input  order_entry_t right,
    input  logic         rem_before,
    input  logic         cand_before,
    input  logic         cand_right,
    output order_entry_t entry,
    output logic         match,
    output logic         cand,
    output logic         rem_le,
    output logic         cand_le
);

    order_entry_t entry_reg;
    order_entry_t entry_next;
    order_entry_t ins;

    assign entry   = entry_reg;
    assign match   = entry_reg.valid && (entry_reg.slot == ctl.key);
    assign cand    = !entry_reg.valid ||
                     (!entry_reg.dirty && ($signed(ctl.prio) >= $signed(entry_reg.prio)));
    assign rem_le  = rem_before || match;
    assign cand_le = cand_before || cand;

    always_comb
    begin
        ins        = '{valid: 1'b1, dirty: 1'b0, slot: ctl.key, prio: ctl.prio};
        entry_next = entry_reg;
        unique case (ctl.op)
            ORD_HOLD:
            begin
                entry_next = entry_reg;
            end
            ORD_MARK:
            begin
                if (match)
                begin
                    entry_next.dirty = 1'b1;
                end
            end
            ORD_REMOVE:
            begin
                if (rem_le)
                begin
                    entry_next = right;
                end
            end
            ORD_RESORT:
            begin
                // removed entry sits ahead of the insertion point: close gap, insert behind
                if (rem_first)
                begin
                    if (cand_right && !cand_le)
                    begin
                        entry_next = ins;
                    end
                    else if (rem_le && !cand_le && !cand_right)
                    begin
                        entry_next = right;
                    end
                end
                else
                begin
                    if (cand && !cand_before)
                    begin
                        entry_next = ins;
                    end
                    else if (cand_before && !rem_before)
                    begin
                        entry_next = left;
                    end
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: src/podl_dirty_cell.sv
module podl_dirty_cell import podl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dirty_ctl_t   ctl,
    input  dirty_entry_t left,
    input  dirty_entry_t right,
    input  logic         rem_before,
    output dirty_entry_t entry,
    output logic         match,
    output logic         rem_le
);

    dirty_entry_t entry_reg;
    dirty_entry_t entry_next;

    assign entry  = entry_reg;
    assign match  = entry_reg.valid && (entry_reg.slot == ctl.key);
    assign rem_le = rem_before || match;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            DRT_HOLD:
            begin
                entry_next = entry_reg;
            end
            DRT_PUSH:
            begin
                entry_next = left;
            end
            DRT_UPDATE:
            begin
                if (match)
                begin
                    entry_next.prio = ctl.prio;
                end
            end
            DRT_REMOVE:
            begin
                if (rem_le)
                begin
                    entry_next = right;
                end
            end
            DRT_POP:
            begin
                entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: bench/podl_dispatch_checker.sv
module podl_dispatch_checker import podl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    podl_req_if  req,
    podl_rsp_if  rsp,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CUR_W-1:0] NIL = CUR_W'(NUM_SLOTS);

    typedef struct packed {
        logic [SLOT_W-1:0] task_slot;
        logic              found;
    } fetch_result_t;

    logic                     in_use   [NUM_SLOTS];
    logic                     dirty    [NUM_SLOTS];
    logic signed [PRIO_W-1:0] prio     [NUM_SLOTS];
    logic [CUR_W-1:0]         ord_next [NUM_SLOTS];
    logic [CUR_W-1:0]         ord_prev [NUM_SLOTS];
    logic [CUR_W-1:0]         drt_next [NUM_SLOTS];
    logic [CUR_W-1:0]         ord_head;
    logic [CUR_W-1:0]         drt_head;
    logic [CUR_W-1:0]         cursor;
    logic                     round_done;

    fetch_result_t expected_fetches[$];

    assign pending = expected_fetches.size();

    function automatic logic signed [PRIO_W-1:0] limit_prio(logic signed [IN_PRIO_W-1:0] raw);
        int v;
        v = raw;
        if (v < -2048)
        begin
            v = -2048;
        end
        if (v > 2048)
        begin
            v = 2048;
        end
        return PRIO_W'(v);
    endfunction

    task automatic clear_model();
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            in_use[k]   = 1'b0;
            dirty[k]    = 1'b0;
            prio[k]     = '0;
            ord_next[k] = NIL;
            ord_prev[k] = NIL;
            drt_next[k] = NIL;
        end
        ord_head   = NIL;
        drt_head   = NIL;
        cursor     = NIL;
        round_done = 1'b1;
    endtask

    task automatic unlink_slot(logic [CUR_W-1:0] s);
        logic [CUR_W-1:0] p;
        logic [CUR_W-1:0] n;
        p = ord_prev[s];
        n = ord_next[s];
        if (p != NIL)
        begin
            ord_next[p] = n;
        end
        if (n != NIL)
        begin
            ord_prev[n] = p;
        end
        if (ord_head == s)
        begin
            ord_head = n;
        end
        ord_prev[s] = NIL;
        ord_next[s] = NIL;
    endtask

    task automatic link_by_priority(logic [CUR_W-1:0] s);
        logic [CUR_W-1:0] j;
        logic [CUR_W-1:0] last;
        logic [CUR_W-1:0] p;
        int               guard;
        j     = ord_head;
        last  = NIL;
        guard = 0;
        if (j == NIL)
        begin
            ord_head = s;
            return;
        end
        while (j != NIL && guard <= NUM_SLOTS)
        begin
            if (!dirty[j] && prio[s] >= prio[j])
            begin
                p           = ord_prev[j];
                ord_prev[s] = p;
                ord_next[s] = j;
                if (p != NIL)
                begin
                    ord_next[p] = s;
                end
                ord_prev[j] = s;
                if (ord_head == j)
                begin
                    ord_head = s;
                end
                return;
            end
            last  = j;
            j     = ord_next[j];
            guard++;
        end
        if (last != NIL)
        begin
            ord_next[last] = s;
            ord_prev[s]    = last;
        end
    endtask

    task automatic remove_slot(logic [CUR_W-1:0] s);
        logic [CUR_W-1:0] k;
        int               guard;
        guard = 0;
        if (cursor == s)
        begin
            cursor = ord_next[s];
        end
        unlink_slot(s);
        if (drt_head == s)
        begin
            drt_head = drt_next[s];
        end
        else if (dirty[s])
        begin
            k = drt_head;
            while (k != NIL && guard <= NUM_SLOTS)
            begin
                if (drt_next[k] == s)
                begin
                    drt_next[k] = drt_next[s];
                    break;
                end
                k = drt_next[k];
                guard++;
            end
        end
        in_use[s]   = 1'b0;
        dirty[s]    = 1'b0;
        drt_next[s] = NIL;
    endtask

    task automatic reorder_dirty();
        logic [CUR_W-1:0] k;
        logic [CUR_W-1:0] nxt;
        int               guard;
        k     = drt_head;
        guard = 0;
        while (k != NIL && guard <= NUM_SLOTS)
        begin
            nxt = drt_next[k];
            unlink_slot(k);
            link_by_priority(k);
            dirty[k]    = 1'b0;
            drt_next[k] = NIL;
            k           = nxt;
            guard++;
        end
        drt_head = NIL;
    endtask

    task automatic push_dirty(logic [CUR_W-1:0] s);
        drt_next[s] = drt_head;
        drt_head    = s;
        dirty[s]    = 1'b1;
    endtask

    task automatic apply_request(mode_t mode, logic [SLOT_W-1:0] sl,
                                 logic signed [IN_PRIO_W-1:0] raw);
        logic [CUR_W-1:0] s;
        logic [CUR_W-1:0] ret;
        fetch_result_t    res;
        s = CUR_W'(sl);
        case (mode)
            MODE_CREATE:
            begin
                if (!in_use[s])
                begin
                    in_use[s]   = 1'b1;
                    prio[s]     = limit_prio(raw);
                    ord_next[s] = NIL;
                    ord_prev[s] = NIL;
                    push_dirty(s);
                end
            end
            MODE_SET_PRIO:
            begin
                if (in_use[s])
                begin
                    prio[s] = limit_prio(raw);
                    if (!dirty[s])
                    begin
                        push_dirty(s);
                    end
                end
            end
            MODE_DESTROY:
            begin
                if (in_use[s])
                begin
                    remove_slot(s);
                end
            end
            default:
            begin
                if (cursor == NIL)
                begin
                    if (!round_done)
                    begin
                        round_done = 1'b1;
                        ret        = NIL;
                    end
                    else
                    begin
                        round_done = 1'b0;
                        reorder_dirty();
                        ret    = ord_head;
                        cursor = (ret != NIL) ? ord_next[ret] : NIL;
                    end
                end
                else
                begin
                    ret    = cursor;
                    cursor = ord_next[cursor];
                end
                res.found     = (ret != NIL);
                res.task_slot = (ret != NIL) ? ret[SLOT_W-1:0] : '0;
                expected_fetches.push_back(res);
            end
        endcase
    endtask

    initial
    begin
        fails = 0;
        clear_model();
    end

    always @(posedge clk or negedge rst_n)
    begin
        fetch_result_t want;
        if (!rst_n)
        begin
            clear_model();
            expected_fetches.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_fetches.size() == 0)
                begin
                    $display("%0t: unexpected result slot=%0d found=%0b", $time,
                             rsp.task_slot, rsp.found);
                    fails++;
                end
                else
                begin
                    want = expected_fetches.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, rsp.found);
                        fails++;
                    end
                    if (rsp.task_slot !== want.task_slot)
                    begin
                        $display("%0t: task_slot expected %0d actual %0d", $time,
                                 want.task_slot, rsp.task_slot);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                apply_request(mode_t'(req.mode), req.slot, req.new_priority);
            end
        end
    end
endmodule

// File: bench/priority_ordered_dispatch_list_core_tb.sv
module priority_ordered_dispatch_list_core_tb import podl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    // When set, both sides run back to back without idle cycles.
    bit   no_idle;

    podl_req_if req ();
    podl_rsp_if rsp ();

    priority_ordered_dispatch_list_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    podl_dispatch_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Draw an idle gap; short bursts of zero keep some back-to-back traffic.
    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Present one request and hold it until the transfer. Valid is lowered
    // only when a gap follows, so it never drops and rises in one step.
    task automatic send(mode_t mode, logic [SLOT_W-1:0] sl,
                        logic signed [IN_PRIO_W-1:0] pr);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.mode         <= mode;
        req.slot         <= sl;
        req.new_priority <= pr;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
    endtask

    // Draw a priority: half the time a narrow band to force ties, else the extremes
    // around the clamp limits or any 16-bit value.
    function automatic logic signed [IN_PRIO_W-1:0] draw_prio();
        case ($urandom_range(0, 5))
            0, 1, 2: return IN_PRIO_W'($signed($urandom_range(0, 40)) - 20);
            3:
            begin
                case ($urandom_range(0, 5))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return -16'sd2048;
                    3: return 16'sd2048;
                    4: return -16'sd2049;
                    default: return 16'sd2049;
                endcase
            end
            default: return IN_PRIO_W'($urandom());
        endcase
    endfunction

    // Respond side: stall for a drawn number of cycles before each transfer.
    initial
    begin
        int gap;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp.valid);
        end
    end

    initial
    begin
        int   pick;
        logic [SLOT_W-1:0] sl;
        req.valid        = 1'b0;
        req.mode         = MODE_CREATE;
        req.slot         = '0;
        req.new_priority = '0;
        no_idle          = 1'b0;
        rst_n            = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fetch on an empty list, both halves of the round.
        send(MODE_FETCH, 6'd0, 16'sd0);
        send(MODE_FETCH, 6'd0, 16'sd0);
        // Extremes of the priority field, clamped and not.
        send(MODE_CREATE, 6'd0, -16'sd32768);
        send(MODE_CREATE, 6'd63, 16'sd32767);
        send(MODE_CREATE, 6'd1, 16'sd2048);
        send(MODE_CREATE, 6'd2, -16'sd2048);
        send(MODE_CREATE, 6'd3, 16'sd2049);
        send(MODE_CREATE, 6'd4, 16'sd0);
        // Create on a used slot, set and destroy on free slots: all ignored.
        send(MODE_CREATE, 6'd4, 16'sd100);
        send(MODE_SET_PRIO, 6'd10, 16'sd5);
        send(MODE_DESTROY, 6'd11, 16'sd0);
        // Set priority twice on a dirty slot; destroy a dirty slot mid-list.
        send(MODE_SET_PRIO, 6'd4, 16'sd7);
        send(MODE_SET_PRIO, 6'd4, -16'sd7);
        send(MODE_DESTROY, 6'd2, 16'sd0);
        send(MODE_FETCH, 6'd0, 16'sd0);
        send(MODE_FETCH, 6'd0, 16'sd0);
        // Destroy the slot just fetched, which lies before the cursor, then drain the round.
        send(MODE_DESTROY, 6'd1, 16'sd0);
        send(MODE_SET_PRIO, 6'd63, -16'sd32768);
        repeat (6) send(MODE_FETCH, 6'd0, 16'sd0);

        // Random: mostly operations on a small pool of slots so the lists
        // grow deep, with full-range slots and fetch bursts mixed in.
        for (int n = 0; n < 900; n++)
        begin
            if (n == 300)
            begin
                // Drop valid and hold off until every outstanding result has arrived.
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            no_idle = (n >= 500 && n < 580);
            pick = $urandom_range(0, 99);
            sl = ($urandom_range(0, 4) == 0) ? SLOT_W'($urandom()) :
                 SLOT_W'($urandom_range(0, 15));
            if (pick < 30)
            begin
                send(MODE_CREATE, sl, draw_prio());
            end
            else if (pick < 45)
            begin
                send(MODE_SET_PRIO, sl, draw_prio());
            end
            else if (pick < 58)
            begin
                send(MODE_DESTROY, sl, IN_PRIO_W'($urandom()));
            end
            else
            begin
                send(MODE_FETCH, SLOT_W'($urandom()), IN_PRIO_W'($urandom()));
            end
        end
        req.valid <= 1'b0;

        // Drain the result queue, then allow for a full reorder pass.
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
